>>> hw/rtl/psched_pkg.sv
// ============================================================================
// psched_pkg: shared types, widths and control store for the priority scheduler
// Holds field widths, the control word layout and the sequencer program.
// ============================================================================
package psched_pkg;

  localparam int MAX_JOBS_DEF = 16;

  localparam int ARR_W      = 16;
  localparam int BURST_W    = 12;
  localparam int PRIO_W     = 8;
  localparam int JOB_W      = ARR_W + BURST_W + PRIO_W;
  localparam int NUM_W      = 5;
  localparam int TIME_W     = 20;
  localparam int SUM_W      = 24;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_PAD_W  = OUT_DATA_W - (NUM_W + 3 * TIME_W + 2 * SUM_W);
  localparam int STEP_W     = 4;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_RUN,
    OP_TAT,
    OP_SUM,
    OP_WSUM,
    OP_OUT_INIT,
    OP_OUT_LOAD,
    OP_EMIT,
    OP_CLEAR
  } op_e;

  // Jump conditions
  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_START,
    COND_SCAN_MORE,
    COND_NOT_FOUND,
    COND_LEFT_MORE,
    COND_OUT_MORE
  } cond_e;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE      = 4'd0;
  localparam step_t ST_SCAN_INIT = 4'd1;
  localparam step_t ST_SCAN      = 4'd2;
  localparam step_t ST_RUN       = 4'd3;
  localparam step_t ST_TAT       = 4'd4;
  localparam step_t ST_SUM       = 4'd5;
  localparam step_t ST_WSUM      = 4'd6;
  localparam step_t ST_OUT_INIT  = 4'd7;
  localparam step_t ST_OUT_LOAD  = 4'd8;
  localparam step_t ST_EMIT      = 4'd9;
  localparam step_t ST_CLEAR     = 4'd10;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    logic  hold_out;  // stall this step while the output register is full and not being taken
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic scan_more;
    logic not_found;
    logic left_more;
    logic out_more;
  } stat_t;

  typedef struct packed {
    logic [NUM_W-1:0]  job_number;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              overflow;
    logic              last_result;
  } result_t;

  // Sequencer program
  function automatic ctrl_t ucode_rom(input step_t step);
    ctrl_t w;
    case (step)
      ST_IDLE:      w = '{OP_IDLE,      COND_NO_START,  1'b0, ST_IDLE};
      ST_SCAN_INIT: w = '{OP_SCAN_INIT, COND_NEXT,      1'b0, ST_IDLE};
      ST_SCAN:      w = '{OP_SCAN,      COND_SCAN_MORE, 1'b0, ST_SCAN};
      ST_RUN:       w = '{OP_RUN,       COND_NOT_FOUND, 1'b0, ST_SCAN_INIT};
      ST_TAT:       w = '{OP_TAT,       COND_NEXT,      1'b0, ST_IDLE};
      ST_SUM:       w = '{OP_SUM,       COND_NEXT,      1'b0, ST_IDLE};
      ST_WSUM:      w = '{OP_WSUM,      COND_LEFT_MORE, 1'b0, ST_SCAN_INIT};
      ST_OUT_INIT:  w = '{OP_OUT_INIT,  COND_NEXT,      1'b0, ST_IDLE};
      ST_OUT_LOAD:  w = '{OP_OUT_LOAD,  COND_NEXT,      1'b0, ST_IDLE};
      ST_EMIT:      w = '{OP_EMIT,      COND_OUT_MORE,  1'b1, ST_OUT_LOAD};
      ST_CLEAR:     w = '{OP_CLEAR,     COND_ALWAYS,    1'b0, ST_IDLE};
      default:      w = '{OP_CLEAR,     COND_ALWAYS,    1'b0, ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/priority_nonpreemptive_scheduler.sv
// Scheduling: after the marked last job the set is scheduled round by round,
// with an extra round for each idle gap; the results are then streamed out.
// Each round scans the job RAM one entry per cycle.
// Throughput: one job loaded per cycle while idle; no job is taken during a set.
// Reset: asynchronous, active low; clears counts, time, sums, flags and the
// sequencer. Job and finish RAMs are not cleared.
// ============================================================================
// priority_nonpreemptive_scheduler: non-preemptive priority job scheduler
// Loads a job set, schedules it with a microcoded sequencer, streams results.
// ============================================================================
module priority_nonpreemptive_scheduler
  import psched_pkg::*;
#(
  parameter int MaxJobs = MAX_JOBS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // arrival_time[15:0], burst_time[27:16], priority_level[35:28], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic                  s_axis_tlast_i,   // last_job
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // job_number[4:0], finish_time[24:5], turnaround_time[44:25],
  // waiting_time[64:45], total_turnaround[88:65], total_waiting[112:89], zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                  m_axis_tuser_o,   // overflow
  output logic                  m_axis_tlast_o    // last_result
);

  ctrl_t   ctrl;
  stat_t   stat;
  logic    out_busy;
  logic    emit;
  result_t result;
  logic    out_valid_q;
  result_t out_res_q;

  assign out_busy = out_valid_q && !m_axis_tready_i;

  psched_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stat_i    (stat),
    .out_busy_i(out_busy),
    .ctrl_o    (ctrl)
  );

  psched_dp #(.MaxJobs(MaxJobs)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_arrival_i(s_axis_tdata_i[ARR_W-1:0]),
    .in_burst_i  (s_axis_tdata_i[ARR_W +: BURST_W]),
    .in_prio_i   (s_axis_tdata_i[ARR_W+BURST_W +: PRIO_W]),
    .in_last_i   (s_axis_tlast_i),
    .out_busy_i  (out_busy),
    .stat_o      (stat),
    .emit_o      (emit),
    .result_o    (result)
  );

  // Output register: load on emit, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_res_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {OUT_PAD_W'(0), out_res_q.total_waiting,
                            out_res_q.total_turnaround, out_res_q.waiting_time,
                            out_res_q.turnaround_time, out_res_q.finish_time,
                            out_res_q.job_number};
  assign m_axis_tuser_o  = out_res_q.overflow;
  assign m_axis_tlast_o  = out_res_q.last_result;

  // Loading and result draining never overlap
  a_no_emit_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !emit)
    else $error("result emitted while jobs are being loaded");

  // A set stays closed to new jobs until its final result is loaded
  a_closed_during_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |-> !s_axis_tready_o)
    else $error("input opened before the final result");

  // Totals only appear on the final result
  a_totals_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |->
      (out_res_q.total_turnaround == '0 && out_res_q.total_waiting == '0))
    else $error("totals on a result that is not the last");

  // Waiting time never exceeds turnaround time
  a_wait_le_tat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_res_q.waiting_time <= out_res_q.turnaround_time))
    else $error("waiting time above turnaround time");

endmodule

>>> hw/rtl/psched_ram.sv
// ============================================================================
// psched_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module psched_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/psched_seq.sv
// ============================================================================
// psched_seq: microcode sequencer
// Step counter over the control store with conditional jumps.
// ============================================================================
module psched_seq
  import psched_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  input  logic  out_busy_i,
  output ctrl_t ctrl_o
);

  step_t upc_q, upc_d;
  ctrl_t ctrl;
  logic  take;

  assign ctrl = ucode_rom(upc_q);

  // Evaluate the jump condition of the current word
  always_comb begin
    case (ctrl.cond)
      COND_NEXT:      take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_START:  take = !stat_i.start;
      COND_SCAN_MORE: take = stat_i.scan_more;
      COND_NOT_FOUND: take = stat_i.not_found;
      COND_LEFT_MORE: take = stat_i.left_more;
      COND_OUT_MORE:  take = stat_i.out_more;
      default:        take = 1'b0;
    endcase
  end

  // Hold, jump or advance
  always_comb begin
    if (ctrl.hold_out && out_busy_i) begin
      upc_d = upc_q;
    end else if (take) begin
      upc_d = ctrl.target;
    end else begin
      upc_d = upc_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

>>> hw/rtl/psched_dp.sv
// ============================================================================
// psched_dp: scheduler datapath
// Job and finish stores, scan registers, time and sums, driven by control words.
// ============================================================================
module psched_dp
  import psched_pkg::*;
#(
  parameter int MaxJobs = MAX_JOBS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ARR_W-1:0]   in_arrival_i,
  input  logic [BURST_W-1:0] in_burst_i,
  input  logic [PRIO_W-1:0]  in_prio_i,
  input  logic               in_last_i,
  input  logic               out_busy_i,
  output stat_t              stat_o,
  output logic               emit_o,
  output result_t            result_o
);

  localparam int IW = $clog2(MaxJobs);
  localparam int CW = $clog2(MaxJobs + 1);

  // Control registers
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      left_q, left_d;
  logic [CW-1:0]      scan_q, scan_d;
  logic [IW-1:0]      eval_q, eval_d;
  logic [CW-1:0]      k_q, k_d;
  logic [TIME_W-1:0]  time_q, time_d;
  logic [SUM_W-1:0]   tsum_q, tsum_d;
  logic [SUM_W-1:0]   wsum_q, wsum_d;
  logic               ovf_q, ovf_d;
  logic               found_q, found_d;
  logic               any_q, any_d;
  logic [MaxJobs-1:0] done_q, done_d;

  // Payload registers
  logic [ARR_W-1:0]   earliest_q, earliest_d;
  logic [PRIO_W-1:0]  best_q, best_d;
  logic [IW-1:0]      pick_q, pick_d;
  logic [ARR_W-1:0]   pick_arr_q, pick_arr_d;
  logic [BURST_W-1:0] pick_burst_q, pick_burst_d;
  logic [TIME_W-1:0]  tat_q, tat_d;
  logic [TIME_W-1:0]  wt_q, wt_d;
  logic [TIME_W-1:0]  fin_q, fin_d;

  // Store ports
  logic               job_we;
  logic [JOB_W-1:0]   job_wdata, job_rdata;
  logic               fin_we;
  logic [IW-1:0]      raddr;
  logic [TIME_W-1:0]  fin_rdata;
  logic [ARR_W-1:0]   rd_arr;
  logic [BURST_W-1:0] rd_burst;
  logic [PRIO_W-1:0]  rd_prio;
  logic [BURST_W-1:0] in_burst_fix;

  logic               in_fire;
  logic [TIME_W:0]    time_sum;
  logic [TIME_W-1:0]  time_sat;
  logic [SUM_W:0]     tsum_sum, wsum_sum;
  logic [CW-1:0]      kn;
  logic               is_last;

  assign in_ready_o   = (ctrl_i.op == OP_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign in_burst_fix = (in_burst_i == '0) ? BURST_W'(1) : in_burst_i;
  assign job_wdata    = {in_prio_i, in_burst_fix, in_arrival_i};

  assign rd_arr   = job_rdata[ARR_W-1:0];
  assign rd_burst = job_rdata[ARR_W +: BURST_W];
  assign rd_prio  = job_rdata[ARR_W+BURST_W +: PRIO_W];

  // Saturating time and sum adders
  assign time_sum = {1'b0, time_q} + (TIME_W+1)'(pick_burst_q);
  assign time_sat = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];
  assign tsum_sum = {1'b0, tsum_q} + (SUM_W+1)'(tat_q);
  assign wsum_sum = {1'b0, wsum_q} + (SUM_W+1)'(wt_q);

  assign kn      = k_q + CW'(1);
  assign is_last = (kn == count_q);

  psched_ram #(.Width(JOB_W), .Depth(MaxJobs)) u_job_ram (
    .clk_i  (clk_i),
    .we_i   (job_we),
    .waddr_i(count_q[IW-1:0]),
    .wdata_i(job_wdata),
    .raddr_i(raddr),
    .rdata_o(job_rdata)
  );

  psched_ram #(.Width(TIME_W), .Depth(MaxJobs)) u_fin_ram (
    .clk_i  (clk_i),
    .we_i   (fin_we),
    .waddr_i(pick_q),
    .wdata_i(time_sat),
    .raddr_i(raddr),
    .rdata_o(fin_rdata)
  );

  // Execute the current control word
  always_comb begin
    count_d      = count_q;
    left_d       = left_q;
    scan_d       = scan_q;
    eval_d       = eval_q;
    k_d          = k_q;
    time_d       = time_q;
    tsum_d       = tsum_q;
    wsum_d       = wsum_q;
    ovf_d        = ovf_q;
    found_d      = found_q;
    any_d        = any_q;
    done_d       = done_q;
    earliest_d   = earliest_q;
    best_d       = best_q;
    pick_d       = pick_q;
    pick_arr_d   = pick_arr_q;
    pick_burst_d = pick_burst_q;
    tat_d        = tat_q;
    wt_d         = wt_q;
    fin_d        = fin_q;
    job_we       = 1'b0;
    fin_we       = 1'b0;
    raddr        = '0;
    case (ctrl_i.op)
      OP_IDLE: begin
        // store the job, or drop it once the table is full
        if (in_fire) begin
          if (count_q < CW'(MaxJobs)) begin
            job_we                   = 1'b1;
            done_d[count_q[IW-1:0]]  = 1'b0;
            count_d                  = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        left_d = count_d;
      end
      OP_SCAN_INIT: begin
        raddr   = '0;
        scan_d  = CW'(1);
        eval_d  = '0;
        found_d = 1'b0;
        any_d   = 1'b0;
      end
      OP_SCAN: begin
        // judge the entry read last cycle, fetch the next one
        raddr  = scan_q[IW-1:0];
        eval_d = scan_q[IW-1:0];
        scan_d = scan_q + CW'(1);
        if (!done_q[eval_q]) begin
          if (!any_q || (rd_arr < earliest_q)) begin
            earliest_d = rd_arr;
          end
          any_d = 1'b1;
          if ((TIME_W'(rd_arr) <= time_q) && (!found_q || (rd_prio > best_q))) begin
            found_d      = 1'b1;
            best_d       = rd_prio;
            pick_d       = eval_q;
            pick_arr_d   = rd_arr;
            pick_burst_d = rd_burst;
          end
        end
      end
      OP_RUN: begin
        // run the picked job to completion, or jump to the next arrival
        if (found_q) begin
          time_d         = time_sat;
          fin_we         = 1'b1;
          done_d[pick_q] = 1'b1;
        end else begin
          time_d = TIME_W'(earliest_q);
        end
      end
      OP_TAT: begin
        tat_d = time_q - TIME_W'(pick_arr_q);
      end
      OP_SUM: begin
        tsum_d = tsum_sum[SUM_W] ? '1 : tsum_sum[SUM_W-1:0];
        wt_d   = tat_q - TIME_W'(pick_burst_q);
      end
      OP_WSUM: begin
        wsum_d = wsum_sum[SUM_W] ? '1 : wsum_sum[SUM_W-1:0];
        left_d = left_q - CW'(1);
      end
      OP_OUT_INIT: begin
        raddr = '0;
        k_d   = '0;
      end
      OP_OUT_LOAD: begin
        raddr        = k_q[IW-1:0];
        tat_d        = fin_rdata - TIME_W'(rd_arr);
        fin_d        = fin_rdata;
        pick_burst_d = rd_burst;
      end
      OP_EMIT: begin
        raddr = kn[IW-1:0];
        if (!out_busy_i) begin
          k_d = kn;
        end
      end
      OP_CLEAR: begin
        count_d = '0;
        time_d  = '0;
        tsum_d  = '0;
        wsum_d  = '0;
        ovf_d   = 1'b0;
        done_d  = '0;
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      left_q  <= '0;
      scan_q  <= '0;
      eval_q  <= '0;
      k_q     <= '0;
      time_q  <= '0;
      tsum_q  <= '0;
      wsum_q  <= '0;
      ovf_q   <= 1'b0;
      found_q <= 1'b0;
      any_q   <= 1'b0;
      done_q  <= '0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
      scan_q  <= scan_d;
      eval_q  <= eval_d;
      k_q     <= k_d;
      time_q  <= time_d;
      tsum_q  <= tsum_d;
      wsum_q  <= wsum_d;
      ovf_q   <= ovf_d;
      found_q <= found_d;
      any_q   <= any_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    earliest_q   <= earliest_d;
    best_q       <= best_d;
    pick_q       <= pick_d;
    pick_arr_q   <= pick_arr_d;
    pick_burst_q <= pick_burst_d;
    tat_q        <= tat_d;
    wt_q         <= wt_d;
    fin_q        <= fin_d;
  end

  // Status back to the sequencer
  assign stat_o.start     = in_fire && in_last_i;
  assign stat_o.scan_more = ((CW'(eval_q) + CW'(1)) != count_q);
  assign stat_o.not_found = !found_q;
  assign stat_o.left_more = (left_q != CW'(1));
  assign stat_o.out_more  = !is_last;

  // Result for the output register
  assign emit_o                    = (ctrl_i.op == OP_EMIT) && !out_busy_i;
  assign result_o.job_number       = NUM_W'(kn);
  assign result_o.finish_time      = fin_q;
  assign result_o.turnaround_time  = tat_q;
  assign result_o.waiting_time     = tat_q - TIME_W'(pick_burst_q);
  assign result_o.total_turnaround = is_last ? tsum_q : '0;
  assign result_o.total_waiting    = is_last ? wsum_q : '0;
  assign result_o.overflow         = ovf_q;
  assign result_o.last_result      = is_last;

endmodule
